[design/epa_pkg.sv]
// shared types and constants of the eased property animator
package epa_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int DUR_W      = 16;
    localparam int VAL_W      = 32;
    localparam int MODE_W     = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DURATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE    = 2'd3;

    // curve codes, the rest act as linear
    localparam logic [MODE_W-1:0] CURVE_LINEAR   = 3'd0;
    localparam logic [MODE_W-1:0] CURVE_EASE_IN  = 3'd1;
    localparam logic [MODE_W-1:0] CURVE_EASE_OUT = 3'd2;
    localparam logic [MODE_W-1:0] CURVE_IN_OUT   = 3'd3;
    localparam logic [MODE_W-1:0] CURVE_SPRING   = 3'd4;

    // request codes
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_UPD, S_CHK, S_DIV, S_SHAPE, S_SQ, S_CUBE, S_CFIN,
        S_ROM0, S_ROM1, S_SPMUL, S_SPFIN, S_INTERP, S_FINAL, S_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_UPD, OP_END, OP_DIV_INIT, OP_DIV_STEP, OP_SHAPE,
        OP_SQ, OP_CUBE, OP_CUBE_FIN, OP_ROM0, OP_ROM1, OP_SP_MUL, OP_SP_FIN,
        OP_INTERP, OP_FINAL, OP_OUT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic              end_only;
        logic              div_last;
        logic              out_free;
        logic [MODE_W-1:0] mode;
    } t_status;

endpackage

[design/epa_ctrl.sv]
// sequencer of the eased property animator
module epa_ctrl import epa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_UPD;
            S_UPD:    n_state = S_CHK;
            S_CHK:    n_state = i_status.end_only ? S_OUT : S_DIV;
            S_DIV:    if (i_status.div_last) n_state = S_SHAPE;
            S_SHAPE: begin
                case (i_status.mode)
                    CURVE_EASE_IN, CURVE_EASE_OUT, CURVE_IN_OUT: n_state = S_SQ;
                    CURVE_SPRING: n_state = S_ROM0;
                    default:      n_state = S_INTERP;
                endcase
            end
            S_SQ:     n_state = S_CUBE;
            S_CUBE:   n_state = S_CFIN;
            S_CFIN:   n_state = S_INTERP;
            S_ROM0:   n_state = S_ROM1;
            S_ROM1:   n_state = S_SPMUL;
            S_SPMUL:  n_state = S_SPFIN;
            S_SPFIN:  n_state = S_INTERP;
            S_INTERP: n_state = S_FINAL;
            S_FINAL:  n_state = S_OUT;
            S_OUT:    if (i_status.out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd.op   = OP_NONE;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = OP_LOAD;
            end
            S_UPD:    o_cmd.op = OP_UPD;
            S_CHK:    o_cmd.op = i_status.end_only ? OP_END : OP_DIV_INIT;
            S_DIV:    o_cmd.op = OP_DIV_STEP;
            S_SHAPE:  o_cmd.op = OP_SHAPE;
            S_SQ:     o_cmd.op = OP_SQ;
            S_CUBE:   o_cmd.op = OP_CUBE;
            S_CFIN:   o_cmd.op = OP_CUBE_FIN;
            S_ROM0:   o_cmd.op = OP_ROM0;
            S_ROM1:   o_cmd.op = OP_ROM1;
            S_SPMUL:  o_cmd.op = OP_SP_MUL;
            S_SPFIN:  o_cmd.op = OP_SP_FIN;
            S_INTERP: o_cmd.op = OP_INTERP;
            S_FINAL:  o_cmd.op = OP_FINAL;
            S_OUT:    if (i_status.out_free) o_cmd.op = OP_OUT;
            default:  o_cmd.op = OP_NONE;
        endcase
    end

endmodule

[design/epa_dpath.sv]
// datapath of the eased property animator: registers, divider, multiplier, spring rom
module epa_dpath import epa_pkg::*; #(
    parameter int FRACTION_BITS      = 16,
    parameter int SPRING_TABLE_DEPTH = 256
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_req_type,
    input  logic [DUR_W-1:0]        i_dt,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [VAL_W-1:0] o_value,
    output logic                    o_animating
);

    localparam int F     = FRACTION_BITS;
    localparam int TW    = F + 1;
    localparam int XW    = F + 2;
    localparam int FW    = F + 3;
    localparam int QW    = DUR_W + F;
    localparam int CW    = $clog2(QW);
    localparam int IW    = $clog2(SPRING_TABLE_DEPTH + 1);
    localparam int PSW   = TW + IW;
    localparam int AW    = 34;
    localparam int MW    = AW + FW;
    localparam int TAB_W = 33;

    localparam logic [TW-1:0]        ONE   = TW'(1) << F;
    localparam logic [TW-1:0]        HALF  = ONE >> 1;
    localparam logic signed [FW-1:0] ONE_F = {2'b00, ONE};

    localparam longint          Q30_ONE      = 64'sd1073741824;
    localparam longint unsigned Q30_PI       = 64'd3373259426;
    localparam longint unsigned Q30_TWO_PI   = 64'd6746518852;
    localparam longint unsigned Q30_SPRING_W = 64'd9298876967;
    localparam longint          EXP_DIV [6]  = '{1, 2, 3, 4, 5, 6};
    localparam longint          COS_DIV [5]  = '{2, 12, 30, 56, 90};

    typedef logic signed [TAB_W-1:0] t_tab [SPRING_TABLE_DEPTH+1];

    // 1 - exp(-5x) cos(5 sqrt3 x) in q2.30, built at elaboration
    function automatic t_tab f_spring_tab();
        t_tab            tab;
        longint unsigned xq;
        longint unsigned th;
        longint          r;
        longint          term;
        longint          sum;
        longint          h;
        longint          h2;
        longint          c;
        for (int k = 0; k <= SPRING_TABLE_DEPTH; k++) begin
            xq   = (longint'(k) << 30) / SPRING_TABLE_DEPTH;
            r    = longint'(xq * 5) >>> 5;
            term = Q30_ONE;
            sum  = Q30_ONE;
            for (int n = 0; n < 6; n++) begin
                term = ((term * r) >>> 30) / EXP_DIV[n];
                sum  = ((n & 1) == 0) ? sum - term : sum + term;
            end
            for (int n = 0; n < 5; n++) sum = (sum * sum) >>> 30;
            th = ((Q30_SPRING_W * xq) >> 30) % Q30_TWO_PI;
            if (th > Q30_PI) th = Q30_TWO_PI - th;
            h    = longint'(th) >>> 3;
            h2   = (h * h) >>> 30;
            term = Q30_ONE;
            c    = Q30_ONE;
            for (int n = 0; n < 5; n++) begin
                term = ((term * h2) >>> 30) / COS_DIV[n];
                c    = ((n & 1) == 0) ? c - term : c + term;
            end
            for (int n = 0; n < 3; n++) c = ((c * c) >>> 30) * 2 - Q30_ONE;
            tab[k] = TAB_W'(Q30_ONE - ((sum * c) >>> 30));
        end
        return tab;
    endfunction

    localparam t_tab SPRING_TAB = f_spring_tab();

    // configuration
    logic [DUR_W-1:0]        r_dur;
    logic signed [VAL_W-1:0] r_start;
    logic signed [VAL_W-1:0] r_end;
    logic [MODE_W-1:0]       r_mode;
    // animation state and latched request
    logic [DUR_W-1:0]        r_elapsed;
    logic                    r_done;
    logic                    r_req;
    logic [DUR_W-1:0]        r_dt;
    // work registers
    logic [DUR_W-1:0]        r_rem;
    logic [QW-1:0]           r_quo;
    logic [CW-1:0]           r_cnt;
    logic [XW-1:0]           r_x;
    logic                    r_lo;
    logic [IW-1:0]           r_idx0;
    logic [IW-1:0]           r_idx1;
    logic [F-1:0]            r_frac;
    logic signed [TAB_W-1:0] r_ta;
    logic signed [TAB_W-1:0] r_tb;
    logic signed [MW-1:0]    r_p;
    logic signed [FW-1:0]    r_f;
    logic signed [VAL_W-1:0] r_val;
    logic                    r_ovalid;
    logic signed [VAL_W-1:0] r_oval;
    logic                    r_oanim;

    logic [DUR_W:0]          w_sum;
    logic [DUR_W:0]          w_trial;
    logic                    w_ge;
    logic [TW-1:0]           w_t;
    logic [PSW-1:0]          w_pos;
    logic [IW:0]             w_pidx;
    logic [XW-1:0]           w_x;
    logic signed [AW-1:0]    w_ma;
    logic signed [FW-1:0]    w_mb;
    logic signed [MW-1:0]    w_prod;
    logic signed [MW-1:0]    w_cube;
    logic signed [MW-1:0]    w_sv;
    logic signed [MW-1:0]    w_fin;
    logic signed [FW-1:0]    w_fc;
    logic signed [VAL_W-1:0] w_sat;
    logic                    w_out_free;

    assign w_sum      = {1'b0, r_elapsed} + {1'b0, r_dt};
    assign w_trial    = {r_rem, r_quo[QW-1]};
    assign w_ge       = w_trial >= {1'b0, r_dur};
    assign w_t        = (r_quo > {{(QW-TW){1'b0}}, ONE}) ? ONE : r_quo[TW-1:0];
    assign w_pos      = PSW'(w_t) * PSW'(SPRING_TABLE_DEPTH);
    assign w_pidx     = w_pos[PSW-1:F];
    assign w_out_free = !r_ovalid || i_out_ready;

    always_comb begin
        case (r_mode)
            CURVE_EASE_IN:  w_x = XW'(w_t);
            CURVE_EASE_OUT: w_x = XW'(ONE - w_t);
            CURVE_IN_OUT:   w_x = (w_t < HALF) ? XW'(w_t)
                                               : (XW'(ONE) << 1) - (XW'(w_t) << 1);
            default:        w_x = '0;
        endcase
    end

    // shared multiplier
    always_comb begin
        case (i_cmd.op)
            OP_SQ: begin
                w_ma = $signed({{(AW-XW){1'b0}}, r_x});
                w_mb = $signed({1'b0, r_x});
            end
            OP_CUBE: begin
                w_ma = AW'(r_p >>> F);
                w_mb = $signed({1'b0, r_x});
            end
            OP_SP_MUL: begin
                w_ma = AW'(r_tb) - AW'(r_ta);
                w_mb = $signed({3'b000, r_frac});
            end
            OP_INTERP: begin
                w_ma = AW'(r_end) - AW'(r_start);
                w_mb = r_f;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = MW'(w_ma) * MW'(w_mb);
    assign w_cube = r_p >>> F;
    assign w_sv   = MW'(r_ta) + (r_p >>> F);
    assign w_fin  = MW'(r_start) + (r_p >>> F);

    always_comb begin
        case (r_mode)
            CURVE_EASE_IN:  w_fc = FW'(w_cube);
            CURVE_EASE_OUT: w_fc = ONE_F - FW'(w_cube);
            CURVE_IN_OUT:   w_fc = r_lo ? (FW'(w_cube) <<< 2) : ONE_F - FW'(w_cube >>> 1);
            default:        w_fc = FW'(w_cube);
        endcase
    end

    // saturate to the 32-bit range
    always_comb begin
        if (&w_fin[MW-1:VAL_W-1] || !(|w_fin[MW-1:VAL_W-1])) begin
            w_sat = w_fin[VAL_W-1:0];
        end else if (w_fin[MW-1]) begin
            w_sat = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur     <= '0;
            r_start   <= '0;
            r_end     <= '0;
            r_mode    <= CURVE_LINEAR;
            r_elapsed <= '0;
            r_done    <= 1'b1;
            r_ovalid  <= 1'b0;
            r_cnt     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_DURATION: r_dur   <= i_cfg_data[DUR_W-1:0];
                    REG_START:    r_start <= i_cfg_data;
                    REG_END:      r_end   <= i_cfg_data;
                    REG_CURVE:    r_mode  <= i_cfg_data[MODE_W-1:0];
                    default:      ;
                endcase
            end
            if (i_cmd.op == OP_UPD) begin
                if (r_req == REQ_START) begin
                    r_elapsed <= '0;
                    r_done    <= 1'b0;
                end else if (!r_done) begin
                    if (w_sum >= {1'b0, r_dur}) begin
                        r_elapsed <= r_dur;
                        r_done    <= 1'b1;
                    end else begin
                        r_elapsed <= w_sum[DUR_W-1:0];
                    end
                end
            end
            if (i_cmd.op == OP_DIV_INIT) r_cnt <= '0;
            if (i_cmd.op == OP_DIV_STEP) r_cnt <= r_cnt + 1'b1;
            if (i_cmd.op == OP_OUT) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_req <= i_req_type;
                r_dt  <= i_dt;
            end
            OP_END: r_val <= r_end;
            OP_DIV_INIT: begin
                r_rem <= '0;
                r_quo <= {r_elapsed, {F{1'b0}}};
            end
            OP_DIV_STEP: begin
                r_rem <= w_ge ? DUR_W'(w_trial - {1'b0, r_dur}) : w_trial[DUR_W-1:0];
                r_quo <= {r_quo[QW-2:0], w_ge};
            end
            OP_SHAPE: begin
                r_x  <= w_x;
                r_lo <= w_t < HALF;
                r_f  <= $signed({2'b00, w_t});
                if (w_pidx >= (IW+1)'(SPRING_TABLE_DEPTH)) begin
                    r_idx0 <= IW'(SPRING_TABLE_DEPTH);
                    r_idx1 <= IW'(SPRING_TABLE_DEPTH);
                    r_frac <= '0;
                end else begin
                    r_idx0 <= w_pidx[IW-1:0];
                    r_idx1 <= w_pidx[IW-1:0] + 1'b1;
                    r_frac <= w_pos[F-1:0];
                end
            end
            OP_SQ, OP_CUBE, OP_SP_MUL, OP_INTERP: r_p <= w_prod;
            OP_CUBE_FIN: r_f  <= w_fc;
            OP_ROM0:     r_ta <= SPRING_TAB[r_idx0];
            OP_ROM1:     r_tb <= SPRING_TAB[r_idx1];
            OP_SP_FIN:   r_f  <= FW'(w_sv >>> (30 - F));
            OP_FINAL:    r_val <= w_sat;
            OP_OUT: begin
                r_oval  <= r_val;
                r_oanim <= !r_done;
            end
            default: ;
        endcase
    end

    assign o_status.end_only = r_done || (r_dur == '0);
    assign o_status.div_last = r_cnt == CW'(QW - 1);
    assign o_status.out_free = w_out_free;
    assign o_status.mode     = r_mode;

    assign o_out_valid = r_ovalid;
    assign o_value     = r_oval;
    assign o_animating = r_oanim;

endmodule

[design/eased_property_animator_unit.sv]
// top level of the eased property animator
//
// channel   direction  handshake                 payload
// request   in         i_in_valid / o_in_ready   i_req_type, i_dt
// result    out        o_out_valid / i_out_ready o_value, o_animating
// config    in         i_cfg_we (no wait)        i_cfg_idx, i_cfg_data
//
// one request at a time; a finished request or an empty animation goes from the check straight to hand-off
// a running one passes the (16 + FRACTION_BITS)-bit bit-serial progress divider and the shape step,
// then square, cube and finish for the cubic curves or rom reads, multiply and finish for the
// spring, while linear goes straight on; all then interpolate, take the final value and hand off
// synchronous active-low reset: config registers and elapsed time zero, animation done, so a tick returns the end value
// a result that is not taken lets the next request transfer in, then holds the sequencer
// at the hand-off of that request until the output register frees
module eased_property_animator_unit import epa_pkg::*; #(
    parameter int FRACTION_BITS      = 16,
    parameter int SPRING_TABLE_DEPTH = 256
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_req_type,
    input  logic [DUR_W-1:0]        i_dt,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [VAL_W-1:0] o_value,
    output logic                    o_animating,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    // commands from the sequencer, status back from the datapath
    t_cmd    w_cmd;
    t_status w_status;

    // sequencer: request transfer, update, check, divide, shape, curve steps, interpolate, final, hand off
    epa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // datapath: config and animation state, divider, shared multiplier, spring rom,
    // output register for the result transfer
    epa_dpath #(
        .FRACTION_BITS      (FRACTION_BITS),
        .SPRING_TABLE_DEPTH (SPRING_TABLE_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_req_type  (i_req_type),
        .i_dt        (i_dt),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_value     (o_value),
        .o_animating (o_animating)
    );

endmodule
